@@ rtl/fvn_pkg.sv @@
// Shared types and constants for the fractal value noise tile block.
package fvn_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW      = 8;
	localparam int COORD_FRAC  = 16;
	localparam int COORD_W     = 10;
	localparam int CX_W        = 24;
	localparam int LEVEL_W     = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int DIV_CNT_W   = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRASS_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRASS_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd6;

	localparam logic [7:0]  SEED_RST       = 8'd0;
	localparam logic [15:0] FREQUENCY_RST  = 16'd3277;
	localparam logic [3:0]  OCTAVES_RST    = 4'd8;
	localparam logic [15:0] GRASS_LOW_RST  = 16'd26214;
	localparam logic [15:0] GRASS_HIGH_RST = 16'd42598;
	localparam logic [10:0] MAP_WIDTH_RST  = 11'd1024;
	localparam logic [10:0] MAP_HEIGHT_RST = 11'd1024;

	localparam logic [1:0] TILE_PATH     = 2'd0;
	localparam logic [1:0] TILE_GRASS    = 2'd1;
	localparam logic [1:0] TILE_OBSTACLE = 2'd2;

	localparam logic KIND_LOAD = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_ROW, ST_LO, ST_HI, ST_BX, ST_MY1, ST_MY2,
		ST_ACC, ST_DINIT, ST_DIV, ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CAPTURE, OP_START, OP_ROW, OP_LO, OP_HI, OP_BX,
		OP_MY1, OP_MY2, OP_ACC, OP_DINIT, OP_DSTEP, OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic last_octave;
		logic last_div;
	} dp_status_t;

endpackage

@@ rtl/fvn_ctrl.sv @@
// Sequencer for octaves, divide steps and the input/output handshakes.
module fvn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	output logic                out_valid,
	input  logic                out_stall,
	input  fvn_pkg::dp_status_t status,
	output fvn_pkg::dp_op_t     op
);

	fvn_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fvn_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != fvn_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		op       = fvn_pkg::OP_NONE;
		out_load = 1'b0;
		unique case (state_q)
			fvn_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (kind == fvn_pkg::KIND_LOAD) begin
						op = fvn_pkg::OP_LOAD;
					end else begin
						op      = fvn_pkg::OP_CAPTURE;
						state_d = fvn_pkg::ST_START;
					end
				end
			end
			fvn_pkg::ST_START: begin
				op      = fvn_pkg::OP_START;
				state_d = fvn_pkg::ST_ROW;
			end
			fvn_pkg::ST_ROW: begin
				op      = fvn_pkg::OP_ROW;
				state_d = fvn_pkg::ST_LO;
			end
			fvn_pkg::ST_LO: begin
				op      = fvn_pkg::OP_LO;
				state_d = fvn_pkg::ST_HI;
			end
			fvn_pkg::ST_HI: begin
				op      = fvn_pkg::OP_HI;
				state_d = fvn_pkg::ST_BX;
			end
			fvn_pkg::ST_BX: begin
				op      = fvn_pkg::OP_BX;
				state_d = fvn_pkg::ST_MY1;
			end
			fvn_pkg::ST_MY1: begin
				op      = fvn_pkg::OP_MY1;
				state_d = fvn_pkg::ST_MY2;
			end
			fvn_pkg::ST_MY2: begin
				op      = fvn_pkg::OP_MY2;
				state_d = fvn_pkg::ST_ACC;
			end
			fvn_pkg::ST_ACC: begin
				op      = fvn_pkg::OP_ACC;
				state_d = status.last_octave ? fvn_pkg::ST_DINIT : fvn_pkg::ST_ROW;
			end
			fvn_pkg::ST_DINIT: begin
				op      = fvn_pkg::OP_DINIT;
				state_d = fvn_pkg::ST_DIV;
			end
			fvn_pkg::ST_DIV: begin
				op = fvn_pkg::OP_DSTEP;
				if (status.last_div)
					state_d = fvn_pkg::ST_DONE;
			end
			fvn_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					op       = fvn_pkg::OP_OUT;
					out_load = 1'b1;
					state_d  = fvn_pkg::ST_IDLE;
				end
			end
			default: state_d = fvn_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/fvn_dp.sv @@
// Datapath: configuration, hash table, smoothstep blends, accumulator, divider.
module fvn_dp #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fvn_pkg::dp_op_t                     op,
	output fvn_pkg::dp_status_t                 status,
	input  logic                                cfg_write_en,
	input  logic [fvn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fvn_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [fvn_pkg::TBL_AW-1:0]          table_index,
	input  logic [7:0]                          table_value,
	input  logic [fvn_pkg::COORD_W-1:0]         x_coord,
	input  logic [fvn_pkg::COORD_W-1:0]         y_coord,
	output logic [fvn_pkg::LEVEL_W-1:0]         noise_level,
	output logic [1:0]                          tile_class
);

	localparam int F      = FRAC_BITS;
	localparam int M      = MAX_OCTAVES;
	localparam int OCT_W  = $clog2(M + 1);
	localparam int SUM_W  = F + 8 + M;
	localparam int T_W    = fvn_pkg::LEVEL_W + M;
	localparam int AW     = fvn_pkg::TBL_AW;
	localparam logic [F:0]   ONE       = (F + 1)'(1) << F;
	localparam logic [F+1:0] THREE_ONE = (F + 2)'(3) << F;

	logic [7:0]  seed_q;
	logic [15:0] freq_q;
	logic [3:0]  octaves_q;
	logic [15:0] glow_q, ghigh_q;
	logic [10:0] mw_q, mh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= fvn_pkg::SEED_RST;
			freq_q    <= fvn_pkg::FREQUENCY_RST;
			octaves_q <= fvn_pkg::OCTAVES_RST;
			glow_q    <= fvn_pkg::GRASS_LOW_RST;
			ghigh_q   <= fvn_pkg::GRASS_HIGH_RST;
			mw_q      <= fvn_pkg::MAP_WIDTH_RST;
			mh_q      <= fvn_pkg::MAP_HEIGHT_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				fvn_pkg::CFG_SEED:       seed_q    <= cfg_data[7:0];
				fvn_pkg::CFG_FREQUENCY:  freq_q    <= cfg_data;
				fvn_pkg::CFG_OCTAVES:    octaves_q <= cfg_data[3:0];
				fvn_pkg::CFG_GRASS_LOW:  glow_q    <= cfg_data;
				fvn_pkg::CFG_GRASS_HIGH: ghigh_q   <= cfg_data;
				fvn_pkg::CFG_MAP_WIDTH:  mw_q      <= cfg_data[10:0];
				fvn_pkg::CFG_MAP_HEIGHT: mh_q      <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// effective octave count, clamped to 1..M
	logic [4:0]       oct_ext;
	logic [OCT_W-1:0] d_eff;
	always_comb begin
		oct_ext = {1'b0, octaves_q};
		if (oct_ext == 5'd0)
			d_eff = OCT_W'(1);
		else if (oct_ext > 5'(M))
			d_eff = OCT_W'(M);
		else
			d_eff = OCT_W'(oct_ext);
	end

	// hash table, two read ports with registered data
	logic [7:0]    mem [fvn_pkg::TABLE_DEPTH];
	logic [AW-1:0] addr0, addr1;
	logic [7:0]    rd0_q, rd1_q, row1_q;

	logic [fvn_pkg::COORD_W-1:0] x_q, y_q;
	logic [fvn_pkg::CX_W-1:0]    cx_q, cy_q;
	logic [AW-1:0]               xi, yi;
	logic [F-1:0]                fx, fy;

	assign xi = cx_q[fvn_pkg::COORD_FRAC +: AW];
	assign yi = cy_q[fvn_pkg::COORD_FRAC +: AW];

	generate
		if (F >= fvn_pkg::COORD_FRAC) begin : g_frac_up
			assign fx = F'(cx_q[fvn_pkg::COORD_FRAC-1:0]) << (F - fvn_pkg::COORD_FRAC);
			assign fy = F'(cy_q[fvn_pkg::COORD_FRAC-1:0]) << (F - fvn_pkg::COORD_FRAC);
		end else begin : g_frac_dn
			assign fx = F'(cx_q[fvn_pkg::COORD_FRAC-1:0] >> (fvn_pkg::COORD_FRAC - F));
			assign fy = F'(cy_q[fvn_pkg::COORD_FRAC-1:0] >> (fvn_pkg::COORD_FRAC - F));
		end
	endgenerate

	always_comb begin
		case (op)
			fvn_pkg::OP_ROW: begin
				addr0 = yi + seed_q;
				addr1 = yi + seed_q + AW'(1);
			end
			fvn_pkg::OP_LO: begin
				addr0 = rd0_q + xi;
				addr1 = rd0_q + xi + AW'(1);
			end
			default: begin
				addr0 = row1_q + xi;
				addr1 = row1_q + xi + AW'(1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (op == fvn_pkg::OP_LOAD)
			mem[table_index] <= table_value;
		rd0_q <= mem[addr0];
		rd1_q <= mem[addr1];
		if (op == fvn_pkg::OP_LO)
			row1_q <= rd1_q;
	end

	// smoothstep and blends
	logic [2*F-1:0]   sqx_full, sqy_full;
	logic [F-1:0]     sqx_q, sqy_q;
	logic [F+1:0]     tx, ty;
	logic [2*F+1:0]   wx_full, wy_full;
	logic [F:0]       wx_q, wy_q;
	logic [F+8:0]     blend_a, blend_b, blend_sum;
	logic [F+7:0]     lo_q, hi_q;
	logic [2*F+8:0]   p_q, pw;
	logic [F+7:0]     v_q;
	logic [SUM_W-1:0] sum_q;

	assign sqx_full  = fx * fx;
	assign sqy_full  = fy * fy;
	assign tx        = THREE_ONE - {1'b0, fx, 1'b0};
	assign ty        = THREE_ONE - {1'b0, fy, 1'b0};
	assign wx_full   = sqx_q * tx;
	assign wy_full   = sqy_q * ty;
	assign blend_a   = (F + 9)'(rd0_q * (ONE - wx_q));
	assign blend_b   = (F + 9)'(rd1_q * wx_q);
	assign blend_sum = blend_a + blend_b;
	assign pw        = p_q + (2 * F + 9)'(hi_q * wy_q);

	// divider state
	logic [OCT_W-1:0]             d_q, oct_cnt_q;
	logic [fvn_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [M-1:0]                 den, rem_q;
	logic [M:0]                   rem2;
	logic [fvn_pkg::LEVEL_W-1:0]  quo_q;
	logic [T_W-1:0]               t_val;

	assign den   = {M{1'b1}} >> (M - int'(d_q));
	assign t_val = T_W'(sum_q >> (F - 8));
	assign rem2  = {rem_q, quo_q[fvn_pkg::LEVEL_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oct_cnt_q <= '0;
			div_cnt_q <= '0;
			d_q       <= OCT_W'(1);
		end else begin
			case (op)
				fvn_pkg::OP_START: begin
					d_q       <= d_eff;
					oct_cnt_q <= d_eff - OCT_W'(1);
				end
				fvn_pkg::OP_ACC:   oct_cnt_q <= oct_cnt_q - OCT_W'(1);
				fvn_pkg::OP_DINIT: div_cnt_q <= '1;
				fvn_pkg::OP_DSTEP: div_cnt_q <= div_cnt_q - fvn_pkg::DIV_CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign status.last_octave = (oct_cnt_q == '0);
	assign status.last_div    = (div_cnt_q == '0);

	logic [25:0] cx_full, cy_full;
	assign cx_full = x_q * freq_q;
	assign cy_full = y_q * freq_q;

	// border and tile class
	logic border;
	logic [1:0] cls;
	always_comb begin
		border = (x_q == '0) || (y_q == '0) ||
			(mw_q != '0 && {1'b0, x_q} == mw_q - 11'd1) ||
			(mh_q != '0 && {1'b0, y_q} == mh_q - 11'd1);
		if (border)
			cls = fvn_pkg::TILE_OBSTACLE;
		else if (quo_q > glow_q && quo_q < ghigh_q)
			cls = fvn_pkg::TILE_GRASS;
		else if (quo_q <= glow_q)
			cls = fvn_pkg::TILE_PATH;
		else
			cls = fvn_pkg::TILE_OBSTACLE;
	end

	always_ff @(posedge clk) begin
		case (op)
			fvn_pkg::OP_CAPTURE: begin
				x_q <= x_coord;
				y_q <= y_coord;
			end
			fvn_pkg::OP_START: begin
				cx_q  <= cx_full[fvn_pkg::CX_W-1:0];
				cy_q  <= cy_full[fvn_pkg::CX_W-1:0];
				sum_q <= '0;
			end
			fvn_pkg::OP_ROW: begin
				sqx_q <= sqx_full[2*F-1:F];
				sqy_q <= sqy_full[2*F-1:F];
			end
			fvn_pkg::OP_LO: begin
				wx_q <= wx_full[2*F:F];
				wy_q <= wy_full[2*F:F];
			end
			fvn_pkg::OP_HI: lo_q <= blend_sum[F+7:0];
			fvn_pkg::OP_BX: hi_q <= blend_sum[F+7:0];
			fvn_pkg::OP_MY1: p_q <= (2 * F + 9)'(lo_q * (ONE - wy_q));
			fvn_pkg::OP_MY2: v_q <= pw[2*F+7:F];
			fvn_pkg::OP_ACC: begin
				// Horner form: earlier octaves end up with the larger weights
				sum_q <= (sum_q << 1) + SUM_W'(v_q);
				cx_q  <= cx_q << 1;
				cy_q  <= cy_q << 1;
			end
			fvn_pkg::OP_DINIT: begin
				rem_q <= t_val[T_W-1:fvn_pkg::LEVEL_W];
				quo_q <= t_val[fvn_pkg::LEVEL_W-1:0];
			end
			fvn_pkg::OP_DSTEP: begin
				if (rem2 >= {1'b0, den}) begin
					rem_q <= M'(rem2 - {1'b0, den});
					quo_q <= {quo_q[fvn_pkg::LEVEL_W-2:0], 1'b1};
				end else begin
					rem_q <= rem2[M-1:0];
					quo_q <= {quo_q[fvn_pkg::LEVEL_W-2:0], 1'b0};
				end
			end
			fvn_pkg::OP_OUT: begin
				noise_level <= quo_q;
				tile_class  <= cls;
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/fractal_value_noise_tiles.sv @@
// Fractal value noise sampler with tile classification, top level.
// A load transaction writes one hash table byte and returns nothing. A sample
// transaction runs from acceptance through START, one pass per clamped octave
// (ROW, LO, HI, BX, MY1, MY2, ACC, with ROW, LO and HI on dependent reads of
// the two-port hash table), DINIT, DIV and DONE to its result in the output
// register; the final normalization is a restoring divider that yields one
// quotient bit per cycle for its 16-bit quotient.
// The input is taken again as soon as the result sits in the output register.
// The hash table has no reset; sample only lattice entries already loaded.
module fractal_value_noise_tiles #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               kind,
	input  logic [fvn_pkg::TBL_AW-1:0]         table_index,
	input  logic [7:0]                         table_value,
	input  logic [fvn_pkg::COORD_W-1:0]        x_coord,
	input  logic [fvn_pkg::COORD_W-1:0]        y_coord,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [fvn_pkg::LEVEL_W-1:0]        noise_level,
	output logic [1:0]                         tile_class,
	input  logic                               cfg_write_en,
	input  logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fvn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fvn_pkg::dp_op_t     op;
	fvn_pkg::dp_status_t status;

	fvn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.op        (op)
	);

	fvn_dp #(
		.MAX_OCTAVES (MAX_OCTAVES),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.status       (status),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.table_index  (table_index),
		.table_value  (table_value),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.noise_level  (noise_level),
		.tile_class   (tile_class)
	);

endmodule
